@@ sv/prtt_pkg.sv @@
`default_nettype none

package prtt_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int COORD_FRAC_BITS_DEF  = 16;

    localparam int FUNC_W   = 3;
    localparam int ANGLE_W  = 17;
    localparam int COORD_W  = 32;
    localparam int SHIFT_W  = 16;
    localparam int SINE_W   = 15;
    localparam int COEF_W   = SINE_W + 1;
    localparam int TURN_W   = 16;
    localparam int REM_W    = 14;

    localparam int FULL_TURN    = 36000;
    localparam int QUARTER_TURN = 9000;

    // pi in Q2.30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 96;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD      = 3'd0,
        FUNC_ROT_X     = 3'd1,
        FUNC_ROT_Y     = 3'd2,
        FUNC_ROT_Z     = 3'd3,
        FUNC_TRANSLATE = 3'd4
    } t_func;

    // slave tdata, first member is the highest bits
    typedef struct packed {
        logic [6:0]                  zero_pad;
        logic signed [SHIFT_W-1:0]   shift_z;
        logic signed [SHIFT_W-1:0]   shift_y;
        logic signed [SHIFT_W-1:0]   shift_x;
        logic signed [COORD_W-1:0]   load_z;
        logic signed [COORD_W-1:0]   load_y;
        logic signed [COORD_W-1:0]   load_x;
        logic signed [ANGLE_W-1:0]   angle_centideg;
    } t_s_data;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_z;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_x;
    } t_m_data;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [COORD_W-1:0] load_x;
        logic signed [COORD_W-1:0] load_y;
        logic signed [COORD_W-1:0] load_z;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic signed [SHIFT_W-1:0] shift_z;
    } t_cmd;

    // a' = cos_k*p + sin_a*q, b' = sin_b*p + cos_k*q
    typedef struct packed {
        logic signed [COEF_W-1:0] cos_k;
        logic signed [COEF_W-1:0] sin_a;
        logic signed [COEF_W-1:0] sin_b;
    } t_coef;

endpackage

`default_nettype wire

@@ sv/prtt_angle.sv @@
`default_nettype none

module prtt_angle #(
    parameter int DEPTH = prtt_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic [3:0]                          i_ld,
    input  logic signed [prtt_pkg::ANGLE_W-1:0] i_angle,
    output logic [1:0]                          o_quad,
    output logic [$clog2(DEPTH+1)-1:0]          o_idx
);
    import prtt_pkg::*;

    localparam int IDX_W    = $clog2(DEPTH + 1);
    localparam int NUM_W    = $clog2(QUARTER_TURN * (DEPTH + 1));
    localparam int RECIP_SH = 42;
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SH) + QUARTER_TURN - 1) / QUARTER_TURN;

    logic signed [ANGLE_W+1:0] w_wrap;
    logic [ANGLE_W:0]          w_pos;
    logic [TURN_W-1:0]         r_turn, n_turn;
    logic [1:0]                r_quad_a, n_quad_a, r_quad_b;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [NUM_W-1:0]          r_num, n_num;
    logic [63:0]               w_prod;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [1:0]                r_quad_c;

    // wrap into 0 .. FULL_TURN-1
    always_comb begin
        w_wrap = (ANGLE_W+2)'(i_angle);
        if (i_angle < 0) begin
            w_wrap = (ANGLE_W+2)'(i_angle) + (ANGLE_W+2)'(2 * FULL_TURN);
        end
        w_pos = w_wrap[ANGLE_W:0];
        if (w_pos >= (ANGLE_W+1)'(FULL_TURN)) begin
            n_turn = TURN_W'(w_pos - (ANGLE_W+1)'(FULL_TURN));
        end else begin
            n_turn = TURN_W'(w_pos);
        end
    end

    always_comb begin
        if (r_turn >= TURN_W'(3 * QUARTER_TURN)) begin
            n_quad_a = 2'd3;
            n_rem    = REM_W'(r_turn - TURN_W'(3 * QUARTER_TURN));
        end else if (r_turn >= TURN_W'(2 * QUARTER_TURN)) begin
            n_quad_a = 2'd2;
            n_rem    = REM_W'(r_turn - TURN_W'(2 * QUARTER_TURN));
        end else if (r_turn >= TURN_W'(QUARTER_TURN)) begin
            n_quad_a = 2'd1;
            n_rem    = REM_W'(r_turn - TURN_W'(QUARTER_TURN));
        end else begin
            n_quad_a = 2'd0;
            n_rem    = REM_W'(r_turn);
        end
    end

    // index = round(rem * DEPTH / QUARTER_TURN), exact reciprocal
    assign n_num  = NUM_W'(32'(r_rem) * 32'(DEPTH) + 32'(QUARTER_TURN / 2));
    assign w_prod = 64'(r_num) * RECIP;
    assign n_idx  = IDX_W'(w_prod >> RECIP_SH);

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_turn <= n_turn;
        end
        if (i_ld[1]) begin
            r_quad_a <= n_quad_a;
            r_rem    <= n_rem;
        end
        if (i_ld[2]) begin
            r_quad_b <= r_quad_a;
            r_num    <= n_num;
        end
        if (i_ld[3]) begin
            r_quad_c <= r_quad_b;
            r_idx    <= n_idx;
        end
    end

    assign o_quad = r_quad_c;
    assign o_idx  = r_idx;

endmodule

`default_nettype wire

@@ sv/prtt_coef.sv @@
`default_nettype none

module prtt_coef #(
    parameter int DEPTH = prtt_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic [1:0]                         i_ld,
    input  logic [$clog2(DEPTH+1)-1:0]         i_idx,
    input  logic [1:0]                         i_quad,
    input  logic [prtt_pkg::FUNC_W-1:0]        i_func,
    output prtt_pkg::t_coef                    o_coef
);
    import prtt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH + 1);

    logic [SINE_W-1:0] w_tab [DEPTH+1];

    // quarter-wave sine, Taylor series to the 15th power, built at elaboration
    for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
        localparam longint unsigned X  = PI_Q30 * 64'(k) / 64'(2 * DEPTH);
        localparam longint unsigned X2 = (X * X) >> 30;
        localparam longint unsigned T1 = ((X  * X2) >> 30) / 64'd6;
        localparam longint unsigned T2 = ((T1 * X2) >> 30) / 64'd20;
        localparam longint unsigned T3 = ((T2 * X2) >> 30) / 64'd42;
        localparam longint unsigned T4 = ((T3 * X2) >> 30) / 64'd72;
        localparam longint unsigned T5 = ((T4 * X2) >> 30) / 64'd110;
        localparam longint unsigned T6 = ((T5 * X2) >> 30) / 64'd156;
        localparam longint unsigned T7 = ((T6 * X2) >> 30) / 64'd210;
        localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2)
                               - longint'(T3) + longint'(T4) - longint'(T5)
                               + longint'(T6) - longint'(T7);
        localparam longint CLIP = (SUM < 0) ? 64'sd0 : SUM;
        localparam longint Q15  = (CLIP + 64'sd16384) >>> 15;
        assign w_tab[k] = SINE_W'((Q15 > 64'sd32767) ? 64'sd32767 : Q15);
    end

    logic [SINE_W-1:0]        r_s0, r_c0;
    logic [1:0]               r_quad;
    logic signed [COEF_W-1:0] w_s0, w_c0, w_s, w_c;
    t_coef                    r_coef, n_coef;

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_s0   <= w_tab[i_idx];
            r_c0   <= w_tab[IDX_W'(DEPTH) - i_idx];
            r_quad <= i_quad;
        end
        if (i_ld[1]) begin
            r_coef <= n_coef;
        end
    end

    always_comb begin
        w_s0 = $signed({1'b0, r_s0});
        w_c0 = $signed({1'b0, r_c0});
        case (r_quad)
            2'd0: begin
                w_s = w_s0;
                w_c = w_c0;
            end
            2'd1: begin
                w_s = w_c0;
                w_c = -w_s0;
            end
            2'd2: begin
                w_s = -w_s0;
                w_c = -w_c0;
            end
            default: begin
                w_s = -w_c0;
                w_c = w_s0;
            end
        endcase

        n_coef.cos_k = w_c;
        case (i_func)
            FUNC_ROT_Y: begin
                n_coef.sin_a = w_s;
                n_coef.sin_b = -w_s;
            end
            default: begin
                n_coef.sin_a = -w_s;
                n_coef.sin_b = w_s;
            end
        endcase
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

@@ sv/prtt_point.sv @@
`default_nettype none

module prtt_point #(
    parameter int COORD_FRAC_BITS = prtt_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_ld,
    input  prtt_pkg::t_cmd                      i_cmd,
    input  prtt_pkg::t_coef                     i_coef,
    output logic signed [prtt_pkg::COORD_W-1:0] o_x,
    output logic signed [prtt_pkg::COORD_W-1:0] o_y,
    output logic signed [prtt_pkg::COORD_W-1:0] o_z,
    output logic                                o_sat
);
    import prtt_pkg::*;

    localparam int PROD_W = COEF_W + COORD_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int RND_W  = ACC_W - (SINE_W);
    localparam int TRN_W  = ((SHIFT_W + COORD_FRAC_BITS > COORD_W) ?
                             SHIFT_W + COORD_FRAC_BITS : COORD_W) + 1;
    localparam int SUM_W  = (TRN_W > RND_W) ? TRN_W : RND_W;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] val;
    } t_sat;

    function automatic t_sat sat_coord(input logic signed [SUM_W-1:0] v);
        t_sat res;
        res.hit = !((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1]));
        if (!res.hit) begin
            res.val = v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            res.val = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            res.val = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    logic signed [COORD_W-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic                      r_sat, n_sat;
    logic signed [COORD_W-1:0] w_p, w_q;
    logic signed [PROD_W-1:0]  w_pa1, w_pa2, w_pb1, w_pb2;
    logic signed [ACC_W-1:0]   w_acc_a, w_acc_b;
    t_sat                      w_ra, w_rb, w_tx, w_ty, w_tz;

    // operand pair for the rotation plane
    always_comb begin
        case (i_cmd.func)
            FUNC_ROT_X: begin
                w_p = r_y;
                w_q = r_z;
            end
            FUNC_ROT_Y: begin
                w_p = r_x;
                w_q = r_z;
            end
            default: begin
                w_p = r_x;
                w_q = r_y;
            end
        endcase
    end

    assign w_pa1 = PROD_W'(i_coef.cos_k) * PROD_W'(w_p);
    assign w_pa2 = PROD_W'(i_coef.sin_a) * PROD_W'(w_q);
    assign w_pb1 = PROD_W'(i_coef.sin_b) * PROD_W'(w_p);
    assign w_pb2 = PROD_W'(i_coef.cos_k) * PROD_W'(w_q);

    // round half up, then drop the Q15 fraction
    assign w_acc_a = ACC_W'(w_pa1) + ACC_W'(w_pa2) + (ACC_W'(1) <<< (SINE_W - 1));
    assign w_acc_b = ACC_W'(w_pb1) + ACC_W'(w_pb2) + (ACC_W'(1) <<< (SINE_W - 1));
    assign w_ra    = sat_coord(SUM_W'(w_acc_a >>> SINE_W));
    assign w_rb    = sat_coord(SUM_W'(w_acc_b >>> SINE_W));

    assign w_tx = sat_coord(SUM_W'(r_x) + (SUM_W'(i_cmd.shift_x) <<< COORD_FRAC_BITS));
    assign w_ty = sat_coord(SUM_W'(r_y) + (SUM_W'(i_cmd.shift_y) <<< COORD_FRAC_BITS));
    assign w_tz = sat_coord(SUM_W'(r_z) + (SUM_W'(i_cmd.shift_z) <<< COORD_FRAC_BITS));

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_z   = r_z;
        n_sat = 1'b0;
        case (i_cmd.func)
            FUNC_LOAD: begin
                n_x = i_cmd.load_x;
                n_y = i_cmd.load_y;
                n_z = i_cmd.load_z;
            end
            FUNC_ROT_X: begin
                n_y   = w_ra.val;
                n_z   = w_rb.val;
                n_sat = w_ra.hit | w_rb.hit;
            end
            FUNC_ROT_Y: begin
                n_x   = w_ra.val;
                n_z   = w_rb.val;
                n_sat = w_ra.hit | w_rb.hit;
            end
            FUNC_ROT_Z: begin
                n_x   = w_ra.val;
                n_y   = w_rb.val;
                n_sat = w_ra.hit | w_rb.hit;
            end
            FUNC_TRANSLATE: begin
                n_x   = w_tx.val;
                n_y   = w_ty.val;
                n_z   = w_tz.val;
                n_sat = w_tx.hit | w_ty.hit | w_tz.hit;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_y   <= '0;
            r_z   <= '0;
            r_sat <= 1'b0;
        end else if (i_ld) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_sat <= n_sat;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_sat = r_sat;

    a_rot_x_keeps_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld && i_cmd.func == FUNC_ROT_X) |=> $stable(r_x))
        else $error("x changed on rotation about x");

    a_no_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld && (i_cmd.func == FUNC_LOAD || i_cmd.func > FUNC_TRANSLATE)) |=> !r_sat)
        else $error("saturation flagged on load or unknown code");

    a_load_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ld && i_cmd.func == FUNC_LOAD) |=> r_x == $past(i_cmd.load_x))
        else $error("loaded x not taken");

endmodule

`default_nettype wire

@@ sv/point_rotate_translate_3d_unit.sv @@
// Point rotate / translate unit.
// Holds one 3D point (signed Q16.16) and applies one transform per slave
// transfer: tuser carries the function (load, rotate about x/y/z, translate),
// tdata the angle in 0.01 degree, the load point and the integer offsets.
// Each slave transfer gives exactly one master transfer with the updated
// point in tdata and the saturation flag in tuser.
// Throughput: one item per cycle while the master does not stall. The angle
// path (wrap, quadrant split, reciprocal index, sine lookup) is pipelined
// ahead of the point; the point registers close a loop of four 16x32
// multiplies, round and saturate, with no register inside it, so
// consecutive items chain without waiting.
// Reset: point cleared to zero, pipeline empty, tvalid low.
// Master stall: the result holds in the output stage; each stage keeps
// taking items while it or a later stage is empty, so up to eight items sit
// in the unit before o_s_tready drops.
`default_nettype none

module point_rotate_translate_3d_unit #(
    parameter int SINE_TABLE_DEPTH = prtt_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int COORD_FRAC_BITS  = prtt_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // angle_centideg, load_x, load_y, load_z, shift_x, shift_y, shift_z, zero pad
    input  logic [prtt_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // func
    input  logic [prtt_pkg::FUNC_W-1:0]        i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // out_x, out_y, out_z
    output logic [prtt_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // saturated
    output logic                               o_m_tuser
);
    import prtt_pkg::*;

    localparam int NUM_STG = 8;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);

    logic [NUM_STG-1:0]        r_vld, w_rdy, w_ld, w_prev;
    t_cmd                      r_cmd [NUM_STG-1];
    t_cmd                      n_cmd;
    t_s_data                   w_s_data;
    t_m_data                   w_m_data;
    logic signed [ANGLE_W-1:0] r_angle;
    logic [1:0]                w_quad;
    logic [IDX_W-1:0]          w_idx;
    t_coef                     w_coef;
    logic signed [COORD_W-1:0] w_x, w_y, w_z;
    logic                      w_sat;

    assign w_rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || i_m_tready;
    for (genvar k = 0; k < NUM_STG - 1; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end
    assign w_prev = {r_vld[NUM_STG-2:0], i_s_tvalid};
    assign w_ld   = w_rdy & w_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (r_vld & ~w_rdy) | (w_prev & w_rdy);
        end
    end

    assign w_s_data      = t_s_data'(i_s_tdata);
    assign n_cmd.func    = i_s_tuser;
    assign n_cmd.load_x  = w_s_data.load_x;
    assign n_cmd.load_y  = w_s_data.load_y;
    assign n_cmd.load_z  = w_s_data.load_z;
    assign n_cmd.shift_x = w_s_data.shift_x;
    assign n_cmd.shift_y = w_s_data.shift_y;
    assign n_cmd.shift_z = w_s_data.shift_z;

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_cmd[0] <= n_cmd;
            r_angle  <= w_s_data.angle_centideg;
        end
        for (int k = 1; k < NUM_STG - 1; k++) begin
            if (w_ld[k]) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
    end

    prtt_angle #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_angle (
        .i_clk   (i_clk),
        .i_ld    (w_ld[4:1]),
        .i_angle (r_angle),
        .o_quad  (w_quad),
        .o_idx   (w_idx)
    );

    prtt_coef #(
        .DEPTH (SINE_TABLE_DEPTH)
    ) u_coef (
        .i_clk  (i_clk),
        .i_ld   (w_ld[6:5]),
        .i_idx  (w_idx),
        .i_quad (w_quad),
        .i_func (r_cmd[5].func),
        .o_coef (w_coef)
    );

    prtt_point #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_point (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ld    (w_ld[NUM_STG-1]),
        .i_cmd   (r_cmd[NUM_STG-2]),
        .i_coef  (w_coef),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_z     (w_z),
        .o_sat   (w_sat)
    );

    assign w_m_data.out_x = w_x;
    assign w_m_data.out_y = w_y;
    assign w_m_data.out_z = w_z;

    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_vld[NUM_STG-1];
    assign o_m_tdata  = w_m_data;
    assign o_m_tuser  = w_sat;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transfer lost at the input stage");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (w_idx <= IDX_W'(SINE_TABLE_DEPTH)))
        else $error("sine index beyond table");

    a_stall_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !w_ld[NUM_STG-1])
        else $error("point updated while result stalled");

endmodule

`default_nettype wire
